### design/ps2_mouse_motion_packetizer_assert.svh
// assertion macros for the ps2 mouse motion packetizer
`ifndef PS2_MOUSE_MOTION_PACKETIZER_ASSERT_SVH
`define PS2_MOUSE_MOTION_PACKETIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PS2MP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PS2MP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ps2mp_pkg.sv
// shared types and constants for the ps2 mouse motion packetizer
`timescale 1ns / 1ps
`default_nettype none

package ps2mp_pkg;

	localparam int MouseCountDef = 2;
	localparam int AccWidthDef   = 16;

	// packets sent per report tick at most
	localparam int MaxPackets = 2;

	// command queue between front and back
	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	typedef enum logic {
		OP_MOTION = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       mouse;
		logic [2:0] buttons;
		logic [7:0] dx;
		logic [7:0] dy;
		logic [7:0] dz;
	} q_entry_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

	// status byte bit positions
	localparam int StY_Ovf  = 7;
	localparam int StX_Ovf  = 6;
	localparam int StY_Sign = 5;
	localparam int StX_Sign = 4;
	localparam int StAlways = 3;

	localparam logic [7:0] OvfNegByte = 8'h80;
	localparam logic [7:0] OvfPosByte = 8'hFF;
	localparam logic [7:0] WheelMin   = 8'hF8;
	localparam logic [7:0] WheelMax   = 8'h07;

endpackage

`default_nettype wire

### design/ps2mp_queue.sv
// two-entry command queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none

module ps2mp_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  ps2mp_pkg::q_entry_t      push_entry,
	input  wire logic                pop,
	output ps2mp_pkg::q_entry_t      head,
	output ps2mp_pkg::q_stat_t       stat
);
	import ps2mp_pkg::*;

	q_entry_t               entry_q [QueueDepth];
	logic [QueuePtrW-1:0]   wr_ptr_q;
	logic [QueuePtrW-1:0]   rd_ptr_q;
	logic [QueuePtrW:0]     cnt_q;
	logic                   do_push;
	logic                   do_pop;

	assign stat.full  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
	assign stat.valid = (cnt_q != '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

### design/ps2mp_front.sv
// input side: takes items, sorts them into motion, tick or drop
`timescale 1ns / 1ps
`default_nettype none

module ps2mp_front #(
	parameter int MOUSE_COUNT = ps2mp_pkg::MouseCountDef
) (
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                command,
	input  wire logic                mouse_select,
	input  wire logic [2:0]          buttons,
	input  wire logic signed [7:0]   move_x,
	input  wire logic signed [7:0]   move_y,
	input  wire logic signed [7:0]   move_z,
	input  ps2mp_pkg::q_stat_t       q_stat,
	output logic                     push,
	output ps2mp_pkg::q_entry_t      push_entry
);
	import ps2mp_pkg::*;

	logic in_range;

	// reports for a mouse that does not exist are taken and dropped
	assign in_range = ({31'd0, mouse_select} < 32'(MOUSE_COUNT));
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready && (command || in_range);

	always_comb begin
		push_entry.op      = command ? OP_TICK : OP_MOTION;
		push_entry.mouse   = mouse_select;
		push_entry.buttons = buttons;
		push_entry.dx      = move_x;
		push_entry.dy      = move_y;
		push_entry.dz      = move_z;
	end

endmodule

`default_nettype wire

### design/ps2mp_back.sv
// execution side: accumulators, tick scan and packet output register
`timescale 1ns / 1ps
`default_nettype none

module ps2mp_back #(
	parameter int MOUSE_COUNT = ps2mp_pkg::MouseCountDef,
	parameter int ACC_WIDTH   = ps2mp_pkg::AccWidthDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  ps2mp_pkg::q_entry_t      head,
	input  ps2mp_pkg::q_stat_t       q_stat,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     mouse_number,
	output logic [7:0]               status_byte,
	output logic [7:0]               x_byte,
	output logic [7:0]               y_byte,
	output logic [7:0]               wheel_byte,
	output logic                     last_packet
);
	import ps2mp_pkg::*;

	localparam int IDX_W = (MOUSE_COUNT > 1) ? $clog2(MOUSE_COUNT) : 1;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX  = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN  = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_WIDTH-1:0] AXIS_LO  = ACC_WIDTH'(-255);
	localparam logic signed [ACC_WIDTH-1:0] AXIS_HI  = ACC_WIDTH'(255);
	localparam logic signed [ACC_WIDTH-1:0] WHEEL_LO = ACC_WIDTH'(-8);
	localparam logic signed [ACC_WIDTH-1:0] WHEEL_HI = ACC_WIDTH'(7);

	logic signed [ACC_WIDTH-1:0] acc_x_q [MOUSE_COUNT];
	logic signed [ACC_WIDTH-1:0] acc_y_q [MOUSE_COUNT];
	logic signed [ACC_WIDTH-1:0] acc_w_q [MOUSE_COUNT];
	logic [2:0]                  btn_q   [MOUSE_COUNT];
	logic [MOUSE_COUNT-1:0]      pend_q;

	logic             state_q;
	logic [IDX_W-1:0] scan_idx_q;
	logic             sent_q;

	logic             out_valid_q;
	logic             mouse_number_q;
	logic [7:0]       status_q;
	logic [7:0]       x_byte_q;
	logic [7:0]       y_byte_q;
	logic [7:0]       wheel_q;
	logic             last_q;

	logic [IDX_W-1:0]            cur_idx;
	logic signed [ACC_WIDTH-1:0] cur_x;
	logic signed [ACC_WIDTH-1:0] cur_y;
	logic signed [ACC_WIDTH-1:0] cur_w;
	logic                        cur_pend;
	logic                        later_pend;
	logic                        at_end;
	logic                        out_free;
	logic                        emit;
	logic                        is_last;
	logic                        do_motion;
	logic                        do_tick;
	logic signed [ACC_WIDTH-1:0] new_x;
	logic signed [ACC_WIDTH-1:0] new_y;
	logic signed [ACC_WIDTH-1:0] new_w;
	logic [7:0]                  enc_x;
	logic [7:0]                  enc_y;
	logic [7:0]                  enc_w;
	logic [7:0]                  enc_status;

	// add or subtract a byte delta, clamped to the accumulator range
	function automatic logic signed [ACC_WIDTH-1:0] sat_add(
		input logic signed [ACC_WIDTH-1:0] acc,
		input logic [7:0]                  delta,
		input logic                        sub
	);
		logic [ACC_WIDTH:0] a_ext;
		logic [ACC_WIDTH:0] d_ext;
		logic [ACC_WIDTH:0] sum;
		a_ext = {acc[ACC_WIDTH-1], acc};
		d_ext = {{(ACC_WIDTH-7){delta[7]}}, delta};
		sum   = sub ? (a_ext - d_ext) : (a_ext + d_ext);
		if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
			return sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
		end
		return sum[ACC_WIDTH-1:0];
	endfunction

	// one read port into the per-mouse state
	assign cur_idx  = (state_q == ST_IDLE) ? IDX_W'(head.mouse) : scan_idx_q;
	assign cur_x    = acc_x_q[cur_idx];
	assign cur_y    = acc_y_q[cur_idx];
	assign cur_w    = acc_w_q[cur_idx];
	assign cur_pend = pend_q[cur_idx];
	assign at_end   = (scan_idx_q == IDX_W'(MOUSE_COUNT - 1));

	always_comb begin
		later_pend = 1'b0;
		for (int i = 0; i < MOUSE_COUNT; i++) begin
			if (i > int'(scan_idx_q) && pend_q[i]) begin
				later_pend = 1'b1;
			end
		end
	end

	assign do_motion = (state_q == ST_IDLE) && q_stat.valid && (head.op == OP_MOTION);
	assign do_tick   = (state_q == ST_IDLE) && q_stat.valid && (head.op == OP_TICK);
	assign pop       = (state_q == ST_IDLE) && q_stat.valid;
	assign out_free  = !out_valid_q || out_ready;
	assign emit      = (state_q == ST_SCAN) && cur_pend && out_free;
	assign is_last   = sent_q || !later_pend;

	assign new_x = sat_add(cur_x, head.dx, 1'b0);
	assign new_y = sat_add(cur_y, head.dy, 1'b1);
	assign new_w = sat_add(cur_w, head.dz, 1'b0);

	always_comb begin
		if (cur_x < AXIS_LO) begin
			enc_x = OvfNegByte;
		end else if (cur_x > AXIS_HI) begin
			enc_x = OvfPosByte;
		end else begin
			enc_x = cur_x[7:0];
		end
		if (cur_y < AXIS_LO) begin
			enc_y = OvfNegByte;
		end else if (cur_y > AXIS_HI) begin
			enc_y = OvfPosByte;
		end else begin
			enc_y = cur_y[7:0];
		end
		if (cur_w < WHEEL_LO) begin
			enc_w = WheelMin;
		end else if (cur_w > WHEEL_HI) begin
			enc_w = WheelMax;
		end else begin
			enc_w = cur_w[7:0];
		end
		enc_status           = {5'd0, btn_q[cur_idx]};
		enc_status[StAlways] = 1'b1;
		enc_status[StX_Sign] = cur_x[ACC_WIDTH-1];
		enc_status[StY_Sign] = cur_y[ACC_WIDTH-1];
		enc_status[StX_Ovf]  = (cur_x < AXIS_LO) || (cur_x > AXIS_HI);
		enc_status[StY_Ovf]  = (cur_y < AXIS_LO) || (cur_y > AXIS_HI);
	end

	// per-mouse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOUSE_COUNT; i++) begin
				acc_x_q[i] <= '0;
				acc_y_q[i] <= '0;
				acc_w_q[i] <= '0;
				btn_q[i]   <= '0;
			end
			pend_q <= '0;
		end else if (do_motion) begin
			acc_x_q[cur_idx] <= new_x;
			acc_y_q[cur_idx] <= new_y;
			acc_w_q[cur_idx] <= new_w;
			btn_q[cur_idx]   <= btn_q[cur_idx] | head.buttons;
			pend_q[cur_idx]  <= 1'b1;
		end else if (emit) begin
			acc_x_q[cur_idx] <= '0;
			acc_y_q[cur_idx] <= '0;
			acc_w_q[cur_idx] <= '0;
			btn_q[cur_idx]   <= '0;
			pend_q[cur_idx]  <= 1'b0;
		end
	end

	// tick sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			sent_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (do_tick) begin
						state_q    <= ST_SCAN;
						scan_idx_q <= '0;
						sent_q     <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (emit) begin
						sent_q <= 1'b1;
						if (is_last || at_end) begin
							state_q <= ST_IDLE;
						end else begin
							scan_idx_q <= scan_idx_q + 1'b1;
						end
					end else if (!cur_pend) begin
						if (at_end) begin
							state_q <= ST_IDLE;
						end else begin
							scan_idx_q <= scan_idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// packet output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			mouse_number_q <= cur_idx[0];
			status_q       <= enc_status;
			x_byte_q       <= enc_x;
			y_byte_q       <= enc_y;
			wheel_q        <= enc_w;
			last_q         <= is_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign mouse_number = mouse_number_q;
	assign status_byte  = status_q;
	assign x_byte       = x_byte_q;
	assign y_byte       = y_byte_q;
	assign wheel_byte   = wheel_q;
	assign last_packet  = last_q;

endmodule

`default_nettype wire

### design/ps2_mouse_motion_packetizer.sv
// top level of the ps2 mouse motion packetizer
`timescale 1ns / 1ps
`default_nettype none

// ps2 mouse motion packetizer: motion reports (command 0) add x, wheel and the
// negated y delta into saturating per-mouse accumulators, or the button bits in
// and set a pending flag; a report tick (command 1) sends one four-byte packet
// (status, x, y, wheel) for each pending mouse in ascending order, at most two
// per tick, marks the final one with last_packet and clears the mice it sent.
// items pass through a two-entry command queue, so up to two more items are still
// taken while a packet waits on the output. a motion report is applied as it
// leaves the queue, so reports stream at one per cycle while no tick is walking;
// a tick leaves the queue, then walks the mice one per cycle, stalled while the
// output is held, until its last packet is sent, or through every mouse when none
// is pending, and nothing behind it in the queue is applied until the walk ends.
// a tick's first packet follows the queue, the scan state and the output register.

module ps2_mouse_motion_packetizer #(
	parameter int MOUSE_COUNT = ps2mp_pkg::MouseCountDef,
	parameter int ACC_WIDTH   = ps2mp_pkg::AccWidthDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input transfer
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               command,
	input  wire logic               mouse_select,
	input  wire logic [2:0]         buttons,
	input  wire logic signed [7:0]  move_x,
	input  wire logic signed [7:0]  move_y,
	input  wire logic signed [7:0]  move_z,
	// packet transfer
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    mouse_number,
	output logic [7:0]              status_byte,
	output logic [7:0]              x_byte,
	output logic [7:0]              y_byte,
	output logic [7:0]              wheel_byte,
	output logic                    last_packet
);
	import ps2mp_pkg::*;

	`include "ps2_mouse_motion_packetizer_assert.svh"

	// front to queue
	logic     push;
	q_entry_t push_entry;
	// queue to back
	q_entry_t head;
	q_stat_t  q_stat;
	logic     pop;

	// classification of incoming items
	ps2mp_front #(
		.MOUSE_COUNT (MOUSE_COUNT)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.mouse_select (mouse_select),
		.buttons      (buttons),
		.move_x       (move_x),
		.move_y       (move_y),
		.move_z       (move_z),
		.q_stat       (q_stat),
		.push         (push),
		.push_entry   (push_entry)
	);

	// decouples the input from the packet engine
	ps2mp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	// accumulators, tick walk and packet register
	ps2mp_back #(
		.MOUSE_COUNT (MOUSE_COUNT),
		.ACC_WIDTH   (ACC_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mouse_number (mouse_number),
		.status_byte  (status_byte),
		.x_byte       (x_byte),
		.y_byte       (y_byte),
		.wheel_byte   (wheel_byte),
		.last_packet  (last_packet)
	);

	// an overflowed axis always carries one of the two overflow bytes
	`PS2MP_ASSERT_NOW(a_x_ovf_byte, out_valid && status_byte[StX_Ovf],
		(x_byte == OvfNegByte) || (x_byte == OvfPosByte), "x overflow byte wrong")
	`PS2MP_ASSERT_NOW(a_y_ovf_byte, out_valid && status_byte[StY_Ovf] && status_byte[StY_Sign],
		y_byte == OvfNegByte, "negative y overflow byte wrong")
	// wheel stays inside its clamp
	`PS2MP_ASSERT_NOW(a_wheel_range, out_valid,
		(wheel_byte <= WheelMax) || (wheel_byte >= WheelMin), "wheel byte out of range")
	// the front never offers an item the queue cannot hold
	`PS2MP_ASSERT_NOW(a_no_push_full, q_stat.full, !push, "push into a full queue")
	// while a packet that is not the last one goes out, the walk is still busy
	`PS2MP_ASSERT_NOW(a_not_last_busy, out_valid && out_ready && !last_packet, !pop,
		"queue read before the tick finished")

endmodule

`default_nettype wire
